>>> design/mipm_pkg.sv
// Shared types and fixed-point constants for the inverse Mobius pixel map.
// Used by every module of the block; depends on nothing else.
package mipm_pkg;

   localparam int FRAC_BITS = 24;
   localparam int CRD_W = 12;
   localparam int DIM_W = 13;
   localparam int QB = DIM_W;
   localparam int NW = 15;
   localparam int DW = FRAC_BITS + 7;
   localparam int PW = DW + NW;
   localparam int MW = 2 * DW - 1;
   localparam int NUMW = PW + FRAC_BITS;
   localparam int CMPW = (NUMW > MW + QB) ? NUMW : MW + QB;

   localparam longint COEF_C = ((64'd3 << FRAC_BITS) + 64'd500) / 64'd1000;
   localparam longint COEF_A = ((64'd21 << FRAC_BITS) + 64'd5) / 64'd10;
   localparam logic signed [DW-1:0] COEF_C_S = DW'(COEF_C);
   localparam logic signed [DW-1:0] COEF_A_S = DW'(COEF_A);

   localparam logic CSR_IMAGE_WIDTH = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;
   localparam logic [DIM_W-1:0] DIM_RESET = 13'd1024;

   typedef struct packed {
      logic [CRD_W-1:0] out_col;
      logic [CRD_W-1:0] out_row;
   } req_word_type;

   typedef struct packed {
      logic [CRD_W-1:0] src_col;
      logic [CRD_W-1:0] src_row;
      logic zero_divisor;
   } rsp_word_type;

   typedef struct packed {
      logic [MW-1:0] m;
      logic zdiv;
      logic xpos;
      logic ypos;
      logic xov;
      logic yov;
      logic [MW-1:0] xrem;
      logic [MW-1:0] yrem;
      logic [QB-1:0] xnum;
      logic [QB-1:0] ynum;
      logic [QB-1:0] xq;
      logic [QB-1:0] yq;
   } div_word_type;

endpackage

>>> design/mobius_inverse_pixel_map_top.sv
// Top level of the inverse Mobius pixel map.
// Depends on mipm_pkg, mipm_front and mipm_div_cell.
//
// The req channel carries one output pixel coordinate per word; the rsp
// channel returns the source column and row for it, plus a flag that is set
// when the divisor was zero. Both channels use valid and stall.
// Each word passes five front stages (divisor, products, sums, range check),
// a chain of thirteen division cells that each produce one quotient bit,
// and one output register.
// A new word is taken every cycle; every stage holds its own valid bit, so
// empty stages keep filling while the receiver stalls, and the block stops
// taking words only once every stage is full.
// Reset empties the pipeline and sets both image dimensions to 1024.
// The csr port writes image_width (index 0) or image_height (index 1); the
// user must see that it is written only while no word is in flight; the block does not check.
module mobius_inverse_pixel_map_top import mipm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic csr_index,
   input  logic [DIM_W-1:0] csr_wdata,
   input  logic req_valid,
   input  req_word_type req_word,
   output logic req_stall,
   output logic rsp_valid,
   output rsp_word_type rsp_word,
   input  logic rsp_stall
);

   logic [DIM_W-1:0] width_ff, height_ff;
   logic rsp_valid_ff;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic cv [QB+1];
   div_word_type cw [QB+1];
   logic cs [QB+1];

   logic out_en;
   div_word_type last;
   logic x_ok, y_ok, both;
   logic [QB-1:0] x_fin, y_fin;
   logic [DIM_W-1:0] row_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: width_ff <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: width_ff <= width_ff;
         endcase
      end
   end

   mipm_front u_front (
      .clock(clock),
      .reset(reset),
      .image_height(height_ff),
      .in_valid(req_valid),
      .in_word(req_word),
      .in_stall(req_stall),
      .out_valid(cv[0]),
      .out_word(cw[0]),
      .out_stall(cs[0])
   );

   for (genvar k = 0; k < QB; k++) begin : g_cell
      mipm_div_cell u_cell (
         .clock(clock),
         .reset(reset),
         .in_valid(cv[k]),
         .in_word(cw[k]),
         .in_stall(cs[k]),
         .out_valid(cv[k+1]),
         .out_word(cw[k+1]),
         .out_stall(cs[k+1])
      );
   end

   assign out_en = !rsp_valid_ff || !rsp_stall;
   assign cs[QB] = !out_en;
   assign last = cw[QB];

   assign x_ok = last.xpos && !last.xov && (last.xq < width_ff);
   assign y_ok = last.ypos && !last.yov && (last.yq < height_ff);
   assign both = x_ok && y_ok && (last.xq != '0) && (last.yq != '0);
   assign x_fin = both ? last.xq : '0;
   assign y_fin = both ? last.yq : '0;
   assign row_full = height_ff - DIM_W'(1) - y_fin;

   always_comb begin
      rsp_word_in.src_col = x_fin[CRD_W-1:0];
      rsp_word_in.src_row = row_full[CRD_W-1:0];
      rsp_word_in.zero_divisor = last.zdiv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= cv[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

endmodule

>>> design/mipm_front.sv
// Front pipeline of the pixel map: divisor, numerator products, sums and
// the quotient range check. Depends on mipm_pkg.
module mipm_front import mipm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic [DIM_W-1:0] image_height,
   input  logic in_valid,
   input  req_word_type in_word,
   output logic in_stall,
   output logic out_valid,
   output div_word_type out_word,
   input  logic out_stall
);

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;

   logic signed [NW-1:0] wr_ff, wi_ff;
   logic signed [DW-1:0] dr_ff, di_ff;
   logic signed [NW-1:0] nr_ff, ni_ff;
   logic signed [PW-1:0] p_nrdr_ff, p_nidi_ff, p_nidr_ff, p_nrdi_ff;
   logic signed [MW:0] sqr_ff, sqi_ff;
   logic signed [PW:0] re_ff, im_ff;
   logic [MW-1:0] m_ff;
   div_word_type word_ff;

   logic signed [PW:0] re_in, im_in;
   logic [NUMW-1:0] nx, ny;
   logic re_pos, im_pos;
   div_word_type word_in;

   assign en5 = !v5_ff || !out_stall;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign in_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   assign re_in = PW'(p_nrdr_ff) + PW'(p_nidi_ff);
   assign im_in = PW'(p_nidr_ff) - PW'(p_nrdi_ff);
   assign re_pos = !re_ff[PW] && (re_ff != '0);
   assign im_pos = !im_ff[PW] && (im_ff != '0);
   assign nx = {re_ff[PW-1:0], {FRAC_BITS{1'b0}}};
   assign ny = {im_ff[PW-1:0], {FRAC_BITS{1'b0}}};

   always_comb begin
      word_in = '0;
      word_in.m = m_ff;
      word_in.zdiv = (m_ff == '0);
      word_in.xpos = re_pos && (m_ff != '0);
      word_in.ypos = im_pos && (m_ff != '0);
      word_in.xov = CMPW'(nx) >= (CMPW'(m_ff) << QB);
      word_in.yov = CMPW'(ny) >= (CMPW'(m_ff) << QB);
      word_in.xrem = MW'(CMPW'(nx) >> QB);
      word_in.yrem = MW'(CMPW'(ny) >> QB);
      word_in.xnum = nx[QB-1:0];
      word_in.ynum = ny[QB-1:0];
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         wr_ff <= $signed(NW'(in_word.out_col));
         wi_ff <= $signed(NW'(image_height)) - $signed(NW'(in_word.out_row));
      end
      if (en2) begin
         dr_ff <= DW'(wr_ff) * COEF_C_S - COEF_A_S;
         di_ff <= DW'(wi_ff) * COEF_C_S - COEF_A_S;
         nr_ff <= wi_ff - wr_ff;
         ni_ff <= -wr_ff - wi_ff;
      end
      if (en3) begin
         p_nrdr_ff <= PW'(nr_ff) * PW'(dr_ff);
         p_nidi_ff <= PW'(ni_ff) * PW'(di_ff);
         p_nidr_ff <= PW'(ni_ff) * PW'(dr_ff);
         p_nrdi_ff <= PW'(nr_ff) * PW'(di_ff);
         sqr_ff <= (MW+1)'(dr_ff) * (MW+1)'(dr_ff);
         sqi_ff <= (MW+1)'(di_ff) * (MW+1)'(di_ff);
      end
      if (en4) begin
         re_ff <= re_in;
         im_ff <= im_in;
         m_ff <= sqr_ff[MW-1:0] + sqi_ff[MW-1:0];
      end
      if (en5) word_ff <= word_in;
   end

   assign out_valid = v5_ff;
   assign out_word = word_ff;

endmodule

>>> design/mipm_div_cell.sv
// One restoring-division cell: yields one quotient bit for each coordinate.
// Depends on mipm_pkg.
module mipm_div_cell import mipm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  div_word_type in_word,
   output logic in_stall,
   output logic out_valid,
   output div_word_type out_word,
   input  logic out_stall
);

   logic valid_ff;
   logic en;
   div_word_type word_ff, word_in;
   logic [MW:0] tx, ty;
   logic gx, gy;

   assign en = !valid_ff || !out_stall;
   assign in_stall = !en;

   assign tx = {in_word.xrem, in_word.xnum[QB-1]};
   assign ty = {in_word.yrem, in_word.ynum[QB-1]};
   assign gx = tx >= {1'b0, in_word.m};
   assign gy = ty >= {1'b0, in_word.m};

   always_comb begin
      word_in = in_word;
      word_in.xrem = gx ? MW'(tx - {1'b0, in_word.m}) : MW'(tx);
      word_in.yrem = gy ? MW'(ty - {1'b0, in_word.m}) : MW'(ty);
      word_in.xnum = {in_word.xnum[QB-2:0], 1'b0};
      word_in.ynum = {in_word.ynum[QB-2:0], 1'b0};
      word_in.xq = {in_word.xq[QB-2:0], gx};
      word_in.yq = {in_word.yq[QB-2:0], gy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word = word_ff;

endmodule

>>> bench/mobius_inverse_pixel_map_top_test.sv
// Testbench for mobius_inverse_pixel_map_top: drives pixel coordinates, predicts each source word
// in exact wide fixed point and checks every result word in order under random stalls.
// Depends on mipm_pkg and the design files of the block.
module mobius_inverse_pixel_map_top_test;
   import mipm_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int LATENCY = 19;
   localparam longint CYCLE_LIMIT = 600000;

   logic clock;
   logic reset;
   logic csr_write;
   logic csr_index;
   logic [DIM_W-1:0] csr_wdata;
   logic req_valid;
   req_word_type req_word;
   logic req_stall;
   logic rsp_valid;
   rsp_word_type rsp_word;
   logic rsp_stall;

   logic [DIM_W-1:0] width_reg;
   logic [DIM_W-1:0] height_reg;
   rsp_word_type expected_words[$];
   int sender_idle_pct;
   int receiver_idle_pct;
   int hold_request;
   int hold_left;
   int error_count;
   int words_sent;
   int words_checked;
   int zero_div_seen;
   longint cycle_count;

   mobius_inverse_pixel_map_top uut (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_word(req_word),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_word(rsp_word),
      .rsp_stall(rsp_stall)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   function automatic rsp_word_type map_pixel(req_word_type w);
      longint wr, wi, dr, di, nr, ni, re, im, xs, ys, hh, ww;
      logic signed [127:0] drw, diw, rew, imw, mag2;
      rsp_word_type r;
      hh = longint'(height_reg);
      ww = longint'(width_reg);
      wr = longint'(w.out_col);
      wi = hh - longint'(w.out_row);
      dr = COEF_C * wr - COEF_A;
      di = COEF_C * wi - COEF_A;
      nr = wi - wr;
      ni = -wr - wi;
      re = nr * dr + ni * di;
      im = ni * dr - nr * di;
      drw = dr;
      diw = di;
      rew = re;
      imw = im;
      mag2 = drw * drw + diw * diw;
      r.zero_divisor = (mag2 == 0);
      xs = 0;
      ys = 0;
      if (mag2 != 0) begin
         xs = longint'((rew * 128'sd16777216) / mag2);
         ys = longint'((imw * 128'sd16777216) / mag2);
      end
      if (ys < 0) ys = 0;
      if (xs < 0) xs = 0;
      if (ys >= hh) ys = 0;
      if (xs >= ww) xs = 0;
      if (xs == 0) ys = 0;
      if (ys == 0) xs = 0;
      r.src_col = CRD_W'(xs);
      r.src_row = CRD_W'(hh - 1 - ys);
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_request > 0) begin
         hold_left <= hold_request - 1;
         hold_request = 0;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word %h", rsp_word);
            error_count++;
         end else begin
            exp_w = expected_words.pop_front();
            words_checked++;
            if (rsp_word.src_col !== exp_w.src_col) begin
               $error("src_col expected %0d actual %0d", exp_w.src_col, rsp_word.src_col);
               error_count++;
            end
            if (rsp_word.src_row !== exp_w.src_row) begin
               $error("src_row expected %0d actual %0d", exp_w.src_row, rsp_word.src_row);
               error_count++;
            end
            if (rsp_word.zero_divisor !== exp_w.zero_divisor) begin
               $error("zero_divisor expected %0d actual %0d", exp_w.zero_divisor,
                      rsp_word.zero_divisor);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d words outstanding", expected_words.size());
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_word(input logic [CRD_W-1:0] col, input logic [CRD_W-1:0] row);
      req_word_type w;
      w.out_col = col;
      w.out_row = row;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      expected_words.push_back(map_pixel(w));
      if (map_pixel(w).zero_divisor) zero_div_seen++;
      words_sent++;
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (LATENCY + 6) @(posedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [DIM_W-1:0] value);
      drain_block();
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (index == CSR_IMAGE_WIDTH) width_reg = value;
      else height_reg = value;
   endtask

   task automatic set_image(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
   endtask

   task automatic test_directed();
      send_word(12'd0, 12'd0);
      send_word(12'd4095, 12'd4095);
      send_word(12'd0, 12'd4095);
      send_word(12'd4095, 12'd0);
      send_word(12'd1, 12'd1);
      send_word(12'd700, 12'd324);
      send_word(12'd700, 12'd323);
      send_word(12'd699, 12'd324);
      send_word(12'd512, 12'd512);
      send_word(12'd1023, 12'd1023);
      send_word(12'd1024, 12'd0);
      send_word(12'd2048, 12'd2048);
      send_word(12'd100, 12'd900);
      send_word(12'd900, 12'd100);
      send_word(12'hAAA, 12'h555);
      send_word(12'h555, 12'hAAA);
   endtask

   task automatic test_random(input int count);
      logic [CRD_W-1:0] c, r;
      int sel;
      repeat (count) begin
         sel = $urandom_range(9);
         if (sel < 4) begin
            c = CRD_W'($urandom_range(4095));
            r = CRD_W'($urandom_range(4095));
         end else if (sel < 8) begin
            c = CRD_W'($urandom_range((width_reg > 4096 || width_reg == 0) ? 4095 :
                                      width_reg - 1));
            r = CRD_W'($urandom_range((height_reg > 4096 || height_reg == 0) ? 4095 :
                                      height_reg - 1));
         end else begin
            c = 12'd690 + CRD_W'($urandom_range(20));
            r = CRD_W'(height_reg) - 12'd700 + CRD_W'($urandom_range(20));
         end
         send_word(c, r);
      end
   endtask

   task automatic test_backpressure();
      hold_request = 300;
      test_random(80);
      drain_block();
      test_random(20);
   endtask

   task automatic test_register_extremes();
      set_image(13'd1, 13'd1);
      test_directed();
      test_random(40);
      set_image(13'd4096, 13'd4096);
      test_directed();
      test_random(60);
      set_image(13'd0, 13'd0);
      test_random(30);
      set_image(13'd8191, 13'd8191);
      test_directed();
      test_random(40);
      set_image(13'd640, 13'd480);
      test_random(60);
   endtask

   initial begin
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_word = '0;
      rsp_stall = 1'b0;
      width_reg = DIM_RESET;
      height_reg = DIM_RESET;
      hold_request = 0;
      error_count = 0;
      words_sent = 0;
      words_checked = 0;
      zero_div_seen = 0;
      cycle_count = 0;
      sender_idle_pct = 15;
      receiver_idle_pct = 74;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(350);
      test_backpressure();
      test_register_extremes();

      sender_idle_pct = 74;
      receiver_idle_pct = 15;
      set_image(13'd1920, 13'd1080);
      test_random(400);
      test_backpressure();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      set_image(13'd1024, 13'd1024);
      test_random(400);
      test_backpressure();

      drain_block();
      $display("Sent %0d coordinate words, checked %0d results (%0d zero divisor).",
               words_sent, words_checked, zero_div_seen);
      $display("Covered image sizes 0, 1, 640x480, 1024, 1920x1080, 4096, 8191 and long stalls.");
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
